// ===== design/ddws_pkg.sv =====
package ddws_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STEPS = 17;
  localparam int ITER_STAGES = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int QUO_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [31:0] Z_HALF_TURN = 32'sd188743680;
  localparam logic signed [31:0] Z_ROUND = 32'sd32768;
  localparam logic [7:0] SPEED_MAX = 8'd100;
  localparam logic [23:0] MS_SCALE = 24'd125;

  typedef enum logic [2:0] {
    REG_TURN_SPEED,
    REG_DRIVE_SPEED,
    REG_TURN_RATE,
    REG_DRIVE_RATE,
    REG_HEADING_TOL,
    REG_DISTANCE_TOL,
    REG_MIN_DURATION,
    REG_MAX_DURATION
  } reg_index_t;

  typedef struct packed {
    logic [6:0]  turn_speed;
    logic [6:0]  drive_speed;
    logic [9:0]  turn_rate_dps;
    logic [9:0]  drive_rate_mmps;
    logic [11:0] heading_tolerance;
    logic [15:0] distance_tolerance;
    logic [9:0]  min_dur_ms;
    logic [9:0]  max_dur_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [12:0]        ch;
    logic signed [12:0] fin;
    logic               gv;
    logic               zero;
  } item_t;

  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [31:0] z;
    logic [34:0]        rem;
    logic [16:0]        root;
    logic               zero;
    logic [12:0]        ch;
    logic signed [12:0] fin;
    logic               gv;
  } iter_t;

  typedef struct packed {
    logic [10:0]        den;
    logic [10:0]        rem;
    logic [QUO_W-1:0]   num;
    logic [QUO_W-1:0]   quo;
    logic               mag_zero;
    logic               spin;
    logic               pos;
    logic               reached;
    logic signed [12:0] herr;
    logic [16:0]        goal_dist;
  } div_t;

  typedef struct packed {
    logic signed [12:0] heading_error;
    logic [16:0]        distance;
    logic [9:0]         cmd_ms;
    logic signed [7:0]  right_speed;
    logic signed [7:0]  left_speed;
    logic               cmd_flag;
    logic               reached;
  } result_t;

  localparam logic signed [31:0] ATAN [0:23] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
    32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
    32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7
  };

  // Brings a difference of two angles into the range of half a turn either way.
  function automatic logic signed [12:0] wrap_angle(input logic signed [14:0] d);
    logic signed [14:0] r;
    r = d;
    if (r >= 15'sd5760) begin
      r = r - 15'sd5760;
    end else if (r <= -15'sd5760) begin
      r = r + 15'sd5760;
    end
    if (r > 15'sd2880) begin
      r = r - 15'sd5760;
    end else if (r < -15'sd2880) begin
      r = r + 15'sd5760;
    end
    return r[12:0];
  endfunction

  function automatic logic [7:0] sat_speed(input logic [6:0] v);
    return ({1'b0, v} > SPEED_MAX) ? SPEED_MAX : {1'b0, v};
  endfunction

endpackage

// ===== design/differential_drive_waypoint_step.sv =====
// Waypoint step for a two-wheeled robot. Each input word carries the current
// pose and a goal point, with an optional goal heading; each output word
// carries one result: arrival flag, command flag, wheel speeds, duration,
// distance and heading error.
// The input side is a stream slave (s_*), the output side a stream master
// (m_*). The configuration port writes one register per cycle with cfg_we,
// and should only be used while no word is in flight.
// A word passes from acceptance to the output register through the
// bit-per-stage square root and CORDIC pipeline and the bit-per-stage
// duration divider.
// One word is accepted every cycle while the receiver is ready.
// Reset clears all valid flags and loads the default register values.
// When the receiver stalls, the back pipeline holds, the two-word queue fills
// and then the input stage stops taking words; nothing is lost.
module differential_drive_waypoint_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // current_x, current_y, current_heading, goal_x, goal_y,
  // goal_angle_valid, goal_angle, zero fill
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reached, command flag, left_speed, right_speed, command duration,
  // distance, heading_error, zero fill
  output logic [63:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  ddws_pkg::cfg_t cfg;
  ddws_pkg::item_t f_item, q_item;
  ddws_pkg::result_t result;
  logic f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_speed <= 7'd60;
      cfg.drive_speed <= 7'd70;
      cfg.turn_rate_dps <= 10'd180;
      cfg.drive_rate_mmps <= 10'd90;
      cfg.heading_tolerance <= 12'd80;
      cfg.distance_tolerance <= 16'd240;
      cfg.min_dur_ms <= 10'd40;
      cfg.max_dur_ms <= 10'd150;
    end else if (cfg_we) begin
      case (ddws_pkg::reg_index_t'(cfg_addr))
        ddws_pkg::REG_TURN_SPEED:   cfg.turn_speed <= cfg_wdata[6:0];
        ddws_pkg::REG_DRIVE_SPEED:  cfg.drive_speed <= cfg_wdata[6:0];
        ddws_pkg::REG_TURN_RATE:    cfg.turn_rate_dps <= cfg_wdata[9:0];
        ddws_pkg::REG_DRIVE_RATE:   cfg.drive_rate_mmps <= cfg_wdata[9:0];
        ddws_pkg::REG_HEADING_TOL:  cfg.heading_tolerance <= cfg_wdata[11:0];
        ddws_pkg::REG_DISTANCE_TOL: cfg.distance_tolerance <= cfg_wdata;
        ddws_pkg::REG_MIN_DURATION: cfg.min_dur_ms <= cfg_wdata[9:0];
        ddws_pkg::REG_MAX_DURATION: cfg.max_dur_ms <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  ddws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  ddws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  ddws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_valid  (q_valid),
    .s_ready  (q_ready),
    .s_item   (q_item),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (result)
  );

  assign m_tdata = {6'b0, result};

endmodule

// ===== design/ddws_front.sv =====
module ddws_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [95:0]     s_tdata,
  output logic            q_valid,
  input  logic            q_ready,
  output ddws_pkg::item_t q_item
);

  logic signed [15:0] cx, cy, gx, gy;
  logic [12:0] ch, ga;
  logic fv;
  ddws_pkg::item_t item, item_next;

  assign cx = s_tdata[15:0];
  assign cy = s_tdata[31:16];
  assign ch = s_tdata[44:32];
  assign gx = s_tdata[60:45];
  assign gy = s_tdata[76:61];
  assign ga = s_tdata[90:78];

  always_comb begin
    item_next.dx = 17'(gx) - 17'(cx);
    item_next.dy = 17'(gy) - 17'(cy);
    item_next.ch = ch;
    item_next.fin = ddws_pkg::wrap_angle($signed({2'b00, ga}) - $signed({2'b00, ch}));
    item_next.gv = s_tdata[77];
    item_next.zero = (gx == cx) && (gy == cy);
  end

  assign s_tready = !fv || q_ready;
  assign q_valid = fv;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/ddws_queue.sv =====
module ddws_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ddws_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ddws_pkg::item_t out_item
);

  ddws_pkg::item_t mem [0:ddws_pkg::QUEUE_DEPTH-1];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = count != 2'(ddws_pkg::QUEUE_DEPTH);
  assign out_valid = count != 2'd0;
  assign out_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== design/ddws_back.sv =====
module ddws_back (
  input  logic              clk,
  input  logic              rst,
  input  ddws_pkg::cfg_t    cfg,
  input  logic              s_valid,
  output logic              s_ready,
  input  ddws_pkg::item_t   s_item,
  output logic              m_valid,
  input  logic              m_ready,
  output ddws_pkg::result_t m_result
);

  localparam int NS = ddws_pkg::ITER_STAGES;
  localparam int QW = ddws_pkg::QUO_W;

  logic en;
  logic va [0:NS];
  logic vd [0:QW];
  logic vo;
  ddws_pkg::iter_t it [0:NS];
  ddws_pkg::div_t dv [0:QW];
  ddws_pkg::iter_t it_first;
  ddws_pkg::div_t dv_first;
  ddws_pkg::result_t res, res_next;

  assign en = !vo || m_ready;
  assign s_ready = en;
  assign m_valid = vo;
  assign m_result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NS; i++) begin
        va[i] <= 1'b0;
      end
      for (int i = 0; i <= QW; i++) begin
        vd[i] <= 1'b0;
      end
      vo <= 1'b0;
    end else if (en) begin
      va[0] <= s_valid;
      for (int i = 0; i < NS; i++) begin
        va[i+1] <= va[i];
      end
      vd[0] <= va[NS];
      for (int i = 0; i < QW; i++) begin
        vd[i+1] <= vd[i];
      end
      vo <= vd[QW];
    end
  end

  // Entry: pre-rotation into the right half plane and the squared distance.
  always_comb begin
    logic signed [27:0] xe, ye;
    logic signed [33:0] sqx, sqy;
    xe = {{3{s_item.dx[16]}}, s_item.dx, 8'b0};
    ye = {{3{s_item.dy[16]}}, s_item.dy, 8'b0};
    sqx = s_item.dx * s_item.dx;
    sqy = s_item.dy * s_item.dy;
    it_first.x = xe;
    it_first.y = ye;
    it_first.z = '0;
    if (s_item.dx[16]) begin
      it_first.x = -xe;
      it_first.y = -ye;
      it_first.z = s_item.dy[16] ? -ddws_pkg::Z_HALF_TURN : ddws_pkg::Z_HALF_TURN;
    end
    it_first.rem = {1'b0, sqx} + {1'b0, sqy};
    it_first.root = '0;
    it_first.zero = s_item.zero;
    it_first.ch = s_item.ch;
    it_first.fin = s_item.fin;
    it_first.gv = s_item.gv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0] <= it_first;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_iter
    localparam int B = (k < ddws_pkg::SQRT_STEPS) ? ddws_pkg::SQRT_STEPS - 1 - k : 0;
    ddws_pkg::iter_t nx;
    always_comb begin
      logic [34:0] trial;
      nx = it[k];
      trial = ({18'b0, it[k].root} << (B + 1)) + (35'd1 << (2 * B));
      if (k < ddws_pkg::CORDIC_STAGES) begin
        if (it[k].y > 28'sd0) begin
          nx.x = it[k].x + (it[k].y >>> k);
          nx.y = it[k].y - (it[k].x >>> k);
          nx.z = it[k].z + ddws_pkg::ATAN[k];
        end else begin
          nx.x = it[k].x - (it[k].y >>> k);
          nx.y = it[k].y + (it[k].x >>> k);
          nx.z = it[k].z - ddws_pkg::ATAN[k];
        end
      end
      if (k < ddws_pkg::SQRT_STEPS) begin
        if (it[k].rem >= trial) begin
          nx.rem = it[k].rem - trial;
          nx.root = it[k].root | (17'd1 << B);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it[k+1] <= nx;
      end
    end
  end

  // Decision stage: bearing, errors, arrival test and the duration dividend.
  always_comb begin
    ddws_pkg::iter_t t;
    logic signed [31:0] zr;
    logic signed [13:0] bearing;
    logic signed [12:0] prim;
    logic [12:0] pmag, fmag;
    logic [16:0] goal_dist, mag;
    logic [9:0] rate;
    logic near, spin;
    t = it[NS];
    zr = (t.z + ddws_pkg::Z_ROUND) >>> 16;
    bearing = t.zero ? 14'sd0 : zr[13:0];
    prim = ddws_pkg::wrap_angle($signed({bearing[13], bearing}) - $signed({2'b00, t.ch}));
    pmag = prim[12] ? 13'(-prim) : 13'(prim);
    fmag = t.fin[12] ? 13'(-t.fin) : 13'(t.fin);
    goal_dist = t.root + 17'(t.rem > {18'b0, t.root});
    near = goal_dist <= {1'b0, cfg.distance_tolerance};
    spin = pmag > {1'b0, cfg.heading_tolerance};
    mag = spin ? {4'b0, pmag} : goal_dist;
    rate = spin ? cfg.turn_rate_dps : cfg.drive_rate_mmps;
    if (rate == 10'd0) begin
      rate = 10'd1;
    end
    dv_first.den = {rate, 1'b0};
    dv_first.rem = '0;
    dv_first.num = {7'b0, mag} * ddws_pkg::MS_SCALE + {14'b0, rate};
    dv_first.quo = '0;
    dv_first.mag_zero = mag == 17'd0;
    dv_first.spin = spin;
    dv_first.pos = !prim[12];
    dv_first.reached = near && (!t.gv || fmag <= {1'b0, cfg.heading_tolerance});
    dv_first.herr = (near && t.gv) ? t.fin : prim;
    dv_first.goal_dist = goal_dist;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv_first;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    ddws_pkg::div_t nd;
    always_comb begin
      logic [11:0] tr;
      nd = dv[j];
      tr = {dv[j].rem, dv[j].num[QW-1]};
      nd.num = dv[j].num << 1;
      if (tr >= {1'b0, dv[j].den}) begin
        nd.rem = 11'(tr - {1'b0, dv[j].den});
        nd.quo = {dv[j].quo[QW-2:0], 1'b1};
      end else begin
        nd.rem = tr[10:0];
        nd.quo = {dv[j].quo[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= nd;
      end
    end
  end

  always_comb begin
    ddws_pkg::div_t d;
    logic [QW-1:0] c;
    logic [9:0] dur;
    logic [7:0] s;
    logic cmd;
    d = dv[QW];
    c = d.quo;
    if (c < {14'b0, cfg.min_dur_ms}) begin
      c = {14'b0, cfg.min_dur_ms};
    end
    if (c > {14'b0, cfg.max_dur_ms}) begin
      c = {14'b0, cfg.max_dur_ms};
    end
    dur = d.mag_zero ? 10'd0 : c[9:0];
    cmd = !d.reached && (dur != 10'd0);
    s = ddws_pkg::sat_speed(d.spin ? cfg.turn_speed : cfg.drive_speed);
    res_next.reached = d.reached;
    res_next.cmd_flag = cmd;
    res_next.cmd_ms = cmd ? dur : 10'd0;
    res_next.distance = d.goal_dist;
    res_next.heading_error = d.herr;
    res_next.left_speed = '0;
    res_next.right_speed = '0;
    if (cmd) begin
      if (!d.spin) begin
        res_next.left_speed = s;
        res_next.right_speed = s;
      end else if (d.pos) begin
        res_next.left_speed = -s;
        res_next.right_speed = s;
      end else begin
        res_next.left_speed = s;
        res_next.right_speed = -s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule
